// ----- src/mac_frame_header_parser_defines.svh -----
// ----------------------------------------------------------------------------
// MAC frame header parser: assertion macros
// Concurrent check helpers shared by the parser RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MAC_FRAME_HEADER_PARSER_DEFINES_SVH
`define MAC_FRAME_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define MFHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define MFHP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define MFHP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFHP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- src/mfhp_pkg.sv -----
// ----------------------------------------------------------------------------
// MAC frame header parser package
// Shared result type, header layout constants and byte insertion helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mfhp_pkg;

    localparam int unsigned C_POS_W = 5;

    localparam logic [C_POS_W-1:0] C_POS_CW_LO    = 5'd0;
    localparam logic [C_POS_W-1:0] C_POS_CW_HI    = 5'd1;
    localparam logic [C_POS_W-1:0] C_POS_SEQ      = 5'd2;
    localparam logic [C_POS_W-1:0] C_DEST_PAN_OFS = 5'd3;
    localparam logic [C_POS_W-1:0] C_PAN_LEN      = 5'd2;
    localparam logic [C_POS_W-1:0] C_SHORT_LEN    = 5'd2;
    localparam logic [C_POS_W-1:0] C_LONG_LEN     = 5'd8;
    localparam logic [C_POS_W-1:0] C_MAX_HDR_LEN  = 5'd23;

    localparam logic [1:0] C_MODE_NONE  = 2'd0;
    localparam logic [1:0] C_MODE_SHORT = 2'd2;

    typedef struct packed {
        logic [1:0]  fc_type;
        logic        fc_pending;
        logic        ack_request;
        logic        pan_id_compress;
        logic [1:0]  dest_mode;
        logic [1:0]  src_mode;
        logic [7:0]  seq_number;
        logic [15:0] dest_pan;
        logic [63:0] dest_address;
        logic [15:0] src_pan;
        logic [63:0] src_address;
        logic [4:0]  header_length;
    } t_result;

    function automatic logic [C_POS_W-1:0] addr_len(input logic [1:0] mode);
        logic [C_POS_W-1:0] len;
        if (mode == C_MODE_NONE) begin
            len = '0;
        end else if (mode == C_MODE_SHORT) begin
            len = C_SHORT_LEN;
        end else begin
            len = C_LONG_LEN;
        end
        return len;
    endfunction

    // replace one byte of a little-endian 64-bit field
    function automatic logic [63:0] put_byte64(input logic [63:0] value,
                                               input logic [2:0]  idx,
                                               input logic [7:0]  b);
        logic [63:0] res;
        res = value;
        for (int i = 0; i < 8; i++) begin
            if (idx == 3'(i)) begin
                res[i*8 +: 8] = b;
            end
        end
        return res;
    endfunction

    function automatic logic [15:0] put_byte16(input logic [15:0] value,
                                               input logic        idx,
                                               input logic [7:0]  b);
        logic [15:0] res;
        res = value;
        if (idx) begin
            res[15:8] = b;
        end else begin
            res[7:0] = b;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/mfhp_parser.sv -----
// ----------------------------------------------------------------------------
// MAC frame header parser: field capture
// Tracks byte position, stores header fields and flags the completing byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mac_frame_header_parser_defines.svh"

module mfhp_parser
    import mfhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_start,
    output logic            o_result_valid,
    output t_result         o_result
);

    logic [C_POS_W-1:0] r_pos,      n_pos;
    logic [15:0]        r_cw,       n_cw;
    logic [7:0]         r_seq,      n_seq;
    logic [15:0]        r_dpan,     n_dpan;
    logic [63:0]        r_daddr,    n_daddr;
    logic [15:0]        r_span,     n_span;
    logic [63:0]        r_saddr,    n_saddr;
    logic               r_done,     n_done;

    logic [C_POS_W-1:0] e_pos;
    logic [15:0]        e_cw;
    logic [1:0]         dmode, smode;
    logic               cmp;
    logic [C_POS_W-1:0] dlen, slen, s0, spl, a0, total, p_inc;
    logic [C_POS_W-1:0] k_dpan, k_daddr, k_span, k_saddr;

    // frame start wipes the fields before the byte is taken as control byte 0
    always_comb begin
        e_pos  = i_frame_start ? '0 : r_pos;
        e_cw   = i_frame_start ? '0 : r_cw;
        dmode  = e_cw[11:10];
        smode  = e_cw[15:14];
        cmp    = e_cw[6];
        dlen   = addr_len(dmode);
        slen   = addr_len(smode);
        s0     = C_DEST_PAN_OFS + ((dmode != C_MODE_NONE) ? (C_PAN_LEN + dlen) : '0);
        spl    = ((smode != C_MODE_NONE) && !cmp) ? C_PAN_LEN : '0;
        a0     = s0 + spl;
        total  = a0 + slen;
        p_inc  = e_pos + 5'd1;
        k_dpan  = e_pos - C_DEST_PAN_OFS;
        k_daddr = e_pos - C_DEST_PAN_OFS - C_PAN_LEN;
        k_span  = e_pos - s0;
        k_saddr = e_pos - a0;
    end

    always_comb begin
        n_pos          = r_pos;
        n_cw           = r_cw;
        n_seq          = r_seq;
        n_dpan         = r_dpan;
        n_daddr        = r_daddr;
        n_span         = r_span;
        n_saddr        = r_saddr;
        n_done         = r_done;
        o_result_valid = 1'b0;
        if (i_accept) begin
            if (i_frame_start) begin
                n_pos   = '0;
                n_cw    = '0;
                n_seq   = '0;
                n_dpan  = '0;
                n_daddr = '0;
                n_span  = '0;
                n_saddr = '0;
                n_done  = 1'b0;
            end
            if (!n_done) begin
                if (e_pos == C_POS_CW_LO) begin
                    n_cw  = {e_cw[15:8], i_data_byte};
                    n_pos = p_inc;
                end else if (e_pos == C_POS_CW_HI) begin
                    n_cw  = {i_data_byte, e_cw[7:0]};
                    n_pos = p_inc;
                end else begin
                    if (e_pos == C_POS_SEQ) begin
                        n_seq = i_data_byte;
                    end else if ((dmode != C_MODE_NONE)
                                 && (e_pos < C_DEST_PAN_OFS + C_PAN_LEN)) begin
                        n_dpan = put_byte16(n_dpan, k_dpan[0], i_data_byte);
                    end else if ((dmode != C_MODE_NONE) && (e_pos < s0)) begin
                        n_daddr = put_byte64(n_daddr, k_daddr[2:0], i_data_byte);
                    end else if ((spl != '0) && (e_pos < a0)) begin
                        n_span = put_byte16(n_span, k_span[0], i_data_byte);
                    end else if (e_pos < total) begin
                        n_saddr = put_byte64(n_saddr, k_saddr[2:0], i_data_byte);
                    end
                    n_pos = p_inc;
                    if (p_inc >= total) begin
                        n_done         = 1'b1;
                        o_result_valid = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_result.fc_type         = n_cw[1:0];
        o_result.fc_pending      = n_cw[4];
        o_result.ack_request     = n_cw[5];
        o_result.pan_id_compress = n_cw[6];
        o_result.dest_mode       = n_cw[11:10];
        o_result.src_mode        = n_cw[15:14];
        o_result.seq_number      = n_seq;
        o_result.dest_pan        = n_dpan;
        o_result.dest_address    = n_daddr;
        o_result.src_pan         = n_span;
        o_result.src_address     = n_saddr;
        o_result.header_length   = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cw    <= '0;
            r_seq   <= '0;
            r_dpan  <= '0;
            r_daddr <= '0;
            r_span  <= '0;
            r_saddr <= '0;
            r_done  <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_cw    <= n_cw;
            r_seq   <= n_seq;
            r_dpan  <= n_dpan;
            r_daddr <= n_daddr;
            r_span  <= n_span;
            r_saddr <= n_saddr;
            r_done  <= n_done;
        end
    end

    `MFHP_ASSERT(a_done_after_result, i_clk, i_rst_n, o_result_valid |=> r_done, "parser not idle after header")
    `MFHP_ASSERT_NEVER(a_pos_in_range, i_clk, i_rst_n, !r_done && (r_pos >= C_MAX_HDR_LEN), "byte position past header end")
    `MFHP_ASSERT_NEVER(a_result_needs_accept, i_clk, i_rst_n, o_result_valid && !i_accept, "result without byte transfer")

endmodule

`default_nettype wire

// ----- src/mfhp_out_buf.sv -----
// ----------------------------------------------------------------------------
// MAC frame header parser: result buffer
// Output register with a skid stage so input transfers continue under stall until the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mac_frame_header_parser_defines.svh"

module mfhp_out_buf
    import mfhp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    take;

    assign take    = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || take) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    `MFHP_ASSERT_NEVER(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid && !r_main_valid, "skid holds data with empty output")
    `MFHP_ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push && r_skid_valid, "result pushed into full buffer")
    `MFHP_ASSERT(a_stall_fills_skid, i_clk, i_rst_n, (i_push && r_main_valid && !i_ready) |=> r_skid_valid, "stalled result lost")

endmodule

`default_nettype wire

// ----- src/mac_frame_header_parser.sv -----
// ----------------------------------------------------------------------------
// MAC frame header parser
// Splits received frame bytes into frame control, sequence and address fields.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_ready     i_data_byte, i_frame_start
//  out      source     o_out_valid / i_out_ready   o_fc_type .. o_header_length
//
//  One byte per cycle while o_in_ready is high; each header byte updates the position counter and one field.
//  The result of the byte that completes the header is registered in the output or skid register.
//  Reset (synchronous, active low) leaves the parser idle until a frame start.
//  Two results may wait in the output and skid registers; input stalls only
//  while both are held.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_frame_header_parser
    import mfhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_fc_type,
    output logic             o_fc_pending,
    output logic             o_ack_request,
    output logic             o_pan_id_compress,
    output logic [1:0]       o_dest_mode,
    output logic [1:0]       o_src_mode,
    output logic [7:0]       o_seq_number,
    output logic [15:0]      o_dest_pan,
    output logic [63:0]      o_dest_address,
    output logic [15:0]      o_src_pan,
    output logic [63:0]      o_src_address,
    output logic [4:0]       o_header_length
);

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_accept = i_in_valid && o_in_ready;

    mfhp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    mfhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_fc_type         = out_res.fc_type;
    assign o_fc_pending      = out_res.fc_pending;
    assign o_ack_request     = out_res.ack_request;
    assign o_pan_id_compress = out_res.pan_id_compress;
    assign o_dest_mode       = out_res.dest_mode;
    assign o_src_mode        = out_res.src_mode;
    assign o_seq_number      = out_res.seq_number;
    assign o_dest_pan        = out_res.dest_pan;
    assign o_dest_address    = out_res.dest_address;
    assign o_src_pan         = out_res.src_pan;
    assign o_src_address     = out_res.src_address;
    assign o_header_length   = out_res.header_length;

endmodule

`default_nettype wire

// ----- tb/mac_frame_header_parser_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MAC frame header parser checker
// Watches both channels, predicts the parsed header for every byte transfer
// and compares each result transfer field by field with the oldest header.
// ----------------------------------------------------------------------------
module mac_frame_header_parser_checker
    import mfhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  fc_type,
    input  logic        fc_pending,
    input  logic        ack_request,
    input  logic        pan_id_compress,
    input  logic [1:0]  dest_mode,
    input  logic [1:0]  src_mode,
    input  logic [7:0]  seq_number,
    input  logic [15:0] dest_pan,
    input  logic [63:0] dest_address,
    input  logic [15:0] src_pan,
    input  logic [63:0] src_address,
    input  logic [4:0]  header_length,
    output int          mismatches,
    output int          headers_pending
);

    // parser copy
    logic [4:0]  hdr_pos;
    logic [15:0] fc_word;
    logic [7:0]  seq_byte;
    logic [15:0] dst_pan_acc;
    logic [63:0] dst_addr_acc;
    logic [15:0] src_pan_acc;
    logic [63:0] src_addr_acc;
    logic        parsing = 1'b0;

    t_result header_q[$];
    t_result want;
    int      fails = 0;

    assign mismatches = fails;

    function automatic int addr_bytes(input logic [1:0] mode);
        int n;
        case (mode)
            C_MODE_NONE:  n = 0;
            C_MODE_SHORT: n = 2;
            default:      n = 8;
        endcase
        return n;
    endfunction

    task automatic clear_fields();
        hdr_pos      = '0;
        fc_word      = '0;
        seq_byte     = '0;
        dst_pan_acc  = '0;
        dst_addr_acc = '0;
        src_pan_acc  = '0;
        src_addr_acc = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic s);
        int      p;
        int      src_ofs;
        int      span_len;
        int      saddr_ofs;
        int      total;
        logic    dst_on;
        t_result hdr;
        if (s) begin
            clear_fields();
            parsing = 1'b1;
        end
        if (parsing) begin
            p = int'(hdr_pos);
            if (p == 0) begin
                fc_word[7:0] = b;
                hdr_pos      = 5'd1;
            end else if (p == 1) begin
                fc_word[15:8] = b;
                hdr_pos       = 5'd2;
            end else begin
                dst_on    = (fc_word[11:10] != C_MODE_NONE);
                src_ofs   = 3 + (dst_on ? 2 + addr_bytes(fc_word[11:10]) : 0);
                span_len  = (fc_word[15:14] != C_MODE_NONE && !fc_word[6]) ? 2 : 0;
                saddr_ofs = src_ofs + span_len;
                total     = saddr_ofs + addr_bytes(fc_word[15:14]);

                if (p == 2) begin
                    seq_byte = b;
                end else if (dst_on && p < 5) begin
                    dst_pan_acc[(p - 3) * 8 +: 8] = b;
                end else if (dst_on && p < src_ofs) begin
                    dst_addr_acc[((p - 5) % 8) * 8 +: 8] = b;
                end else if (span_len != 0 && p < saddr_ofs) begin
                    src_pan_acc[(p - src_ofs) * 8 +: 8] = b;
                end else if (p < total) begin
                    src_addr_acc[((p - saddr_ofs) % 8) * 8 +: 8] = b;
                end

                p++;
                hdr_pos = p[4:0];
                if (p >= total) begin
                    parsing             = 1'b0;
                    hdr.fc_type         = fc_word[1:0];
                    hdr.fc_pending      = fc_word[4];
                    hdr.ack_request     = fc_word[5];
                    hdr.pan_id_compress = fc_word[6];
                    hdr.dest_mode       = fc_word[11:10];
                    hdr.src_mode        = fc_word[15:14];
                    hdr.seq_number      = seq_byte;
                    hdr.dest_pan        = dst_pan_acc;
                    hdr.dest_address    = dst_addr_acc;
                    hdr.src_pan         = src_pan_acc;
                    hdr.src_address     = src_addr_acc;
                    hdr.header_length   = p[4:0];
                    header_q.push_back(hdr);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_fields();
            parsing = 1'b0;
            header_q.delete();
        end else begin
            if (in_valid && in_ready) begin
                parse_byte(data_byte, frame_start);
            end
            if (out_valid && out_ready) begin
                if (header_q.size() == 0) begin
                    $error("result transfer with no header expected");
                    fails++;
                end else begin
                    want = header_q.pop_front();
                    check_field("fc_type", 64'(want.fc_type), 64'(fc_type));
                    check_field("fc_pending", 64'(want.fc_pending), 64'(fc_pending));
                    check_field("ack_request", 64'(want.ack_request), 64'(ack_request));
                    check_field("pan_id_compress", 64'(want.pan_id_compress),
                                64'(pan_id_compress));
                    check_field("dest_mode", 64'(want.dest_mode), 64'(dest_mode));
                    check_field("src_mode", 64'(want.src_mode), 64'(src_mode));
                    check_field("seq_number", 64'(want.seq_number), 64'(seq_number));
                    check_field("dest_pan", 64'(want.dest_pan), 64'(dest_pan));
                    check_field("dest_address", want.dest_address, dest_address);
                    check_field("src_pan", 64'(want.src_pan), 64'(src_pan));
                    check_field("src_address", want.src_address, src_address);
                    check_field("header_length", 64'(want.header_length),
                                64'(header_length));
                end
            end
        end
        // registered so the stimulus side always reads last edge's count
        headers_pending <= header_q.size();
    end

endmodule

// ----- tb/mac_frame_header_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MAC frame header parser testbench
// Feeds directed and random frames (complete, truncated and noise bytes)
// under several idle/stall mixes; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module mac_frame_header_parser_tb
    import mfhp_pkg::*;
();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_data = 8'h00;
    logic        in_start = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  fc_type;
    logic        fc_pending;
    logic        ack_request;
    logic        pan_id_compress;
    logic [1:0]  dest_mode;
    logic [1:0]  src_mode;
    logic [7:0]  seq_number;
    logic [15:0] dest_pan;
    logic [63:0] dest_address;
    logic [15:0] src_pan;
    logic [63:0] src_address;
    logic [4:0]  header_length;

    int mismatches;
    int headers_pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    mac_frame_header_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (in_data),
        .i_frame_start     (in_start),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_fc_type         (fc_type),
        .o_fc_pending      (fc_pending),
        .o_ack_request     (ack_request),
        .o_pan_id_compress (pan_id_compress),
        .o_dest_mode       (dest_mode),
        .o_src_mode        (src_mode),
        .o_seq_number      (seq_number),
        .o_dest_pan        (dest_pan),
        .o_dest_address    (dest_address),
        .o_src_pan         (src_pan),
        .o_src_address     (src_address),
        .o_header_length   (header_length)
    );

    mac_frame_header_parser_checker u_checker (
        .clk             (i_clk),
        .rst_n           (i_rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (in_data),
        .frame_start     (in_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fc_type         (fc_type),
        .fc_pending      (fc_pending),
        .ack_request     (ack_request),
        .pan_id_compress (pan_id_compress),
        .dest_mode       (dest_mode),
        .src_mode        (src_mode),
        .seq_number      (seq_number),
        .dest_pan        (dest_pan),
        .dest_address    (dest_address),
        .src_pan         (src_pan),
        .src_address     (src_address),
        .header_length   (header_length),
        .mismatches      (mismatches),
        .headers_pending (headers_pending)
    );

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int frame_header_bytes(input logic [15:0] cw);
        int n;
        n = 3;
        case (cw[11:10])
            C_MODE_NONE:  n += 0;
            C_MODE_SHORT: n += 4;
            default:      n += 10;
        endcase
        if (cw[15:14] != C_MODE_NONE) begin
            if (!cw[6]) n += 2;
            n += (cw[15:14] == C_MODE_SHORT) ? 2 : 8;
        end
        return n;
    endfunction

    // one byte transfer; random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            in_data  <= 8'($urandom);
            in_start <= 1'($urandom);
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_start <= s;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // first n_send header bytes of a frame, then n_trail payload bytes
    task automatic send_frame(input logic [15:0] cw, input int n_send, input int n_trail);
        send_byte(cw[7:0], 1'b1);
        if (n_send > 1) send_byte(cw[15:8], 1'b0);
        for (int i = 2; i < n_send; i++) begin
            send_byte(8'($urandom), 1'b0);
        end
        repeat (n_trail) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (headers_pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        int         goal;
        int         pick;
        int         len;
        logic [15:0] cw;
        int         idle_tab[4];
        int         stall_tab[4];
        idle_tab  = '{0, 63, 0, 15};
        stall_tab = '{0, 0, 63, 15};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle after reset: no start, ignored
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        // minimal header, no addressing
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // header abandoned by a new start
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        // short dest, long src (mode 1), compressed, all flags set
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7B, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0);
        // trailing payload byte, ignored
        send_byte(8'h00, 1'b0);
        drain_results();

        goal = bytes_sent;
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct  = idle_tab[ph % 4];
            stall_pct = stall_tab[ph % 4];
            goal += 190;
            while (bytes_sent < goal) begin
                pick = $urandom_range(99);
                cw   = 16'($urandom);
                len  = frame_header_bytes(cw);
                if (pick < 80) begin
                    send_frame(cw, len, $urandom_range(2));
                end else if (pick < 90) begin
                    send_frame(cw, $urandom_range(len - 1, 1), 0);
                end else begin
                    send_byte(8'($urandom), ($urandom_range(7) == 0));
                end
            end
            drain_results();
        end

        idle_pct  = 0;
        stall_pct = 0;
        in_valid <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; w < 20000 && headers_pending != 0; w++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (headers_pending != 0) begin
            $error("%0d headers never arrived", headers_pending);
        end

        if (mismatches == 0 && headers_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/mfhp_pkg.sv
src/mfhp_parser.sv
src/mfhp_out_buf.sv
src/mac_frame_header_parser.sv
tb/mac_frame_header_parser_checker.sv
tb/mac_frame_header_parser_tb.sv
